// File: rtl/btffa_pkg.sv
package btffa_pkg;

    typedef logic [4:0] cmd_t;

    localparam cmd_t CMD_NOP       = 5'd0;
    localparam cmd_t CMD_CLR       = 5'd1;
    localparam cmd_t CMD_INIT_H    = 5'd2;
    localparam cmd_t CMD_INIT_F    = 5'd3;
    localparam cmd_t CMD_ACCEPT    = 5'd4;
    localparam cmd_t CMD_RD_HS     = 5'd5;
    localparam cmd_t CMD_RD_FT     = 5'd6;
    localparam cmd_t CMD_NEXT      = 5'd7;
    localparam cmd_t CMD_TAKE      = 5'd8;
    localparam cmd_t CMD_SPLIT1    = 5'd9;
    localparam cmd_t CMD_SPLIT2    = 5'd10;
    localparam cmd_t CMD_SPLIT3    = 5'd11;
    localparam cmd_t CMD_SPLIT4    = 5'd12;
    localparam cmd_t CMD_SET_BIG   = 5'd13;
    localparam cmd_t CMD_SET_NOFIT = 5'd14;
    localparam cmd_t CMD_F_CLR_FT  = 5'd15;
    localparam cmd_t CMD_F_RD_LF   = 5'd16;
    localparam cmd_t CMD_F_RD_LH   = 5'd17;
    localparam cmd_t CMD_F_WR_LH   = 5'd18;
    localparam cmd_t CMD_F_WR_LF   = 5'd19;
    localparam cmd_t CMD_F_RD_NS   = 5'd20;
    localparam cmd_t CMD_F_RD_NF   = 5'd21;
    localparam cmd_t CMD_F_WR_NF   = 5'd22;
    localparam cmd_t CMD_F_WR_NH   = 5'd23;
    localparam cmd_t CMD_OUT       = 5'd24;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_BIG   = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;

    typedef struct packed {
        cmd_t cmd;
    } ctrl_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic req_big;
        logic reg_bad;
        logic pos_end;
        logic hs_bad;
        logic fit;
        logic split;
        logic ft_match;
        logic p_zero;
        logic lf_ok;
        logic q_end;
        logic ns_bad;
        logic nf_even;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/btffa_ram.sv
module btffa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/btffa_ctrl.sv
module btffa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  btffa_pkg::stat_t  stat,
    output btffa_pkg::ctrl_t  ctrl
);

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_INIT_H = 5'd1;
    localparam logic [4:0] S_INIT_F = 5'd2;
    localparam logic [4:0] S_IDLE   = 5'd3;
    localparam logic [4:0] S_ENTRY  = 5'd4;
    localparam logic [4:0] S_A_TEST = 5'd5;
    localparam logic [4:0] S_A_HS   = 5'd6;
    localparam logic [4:0] S_A_FT   = 5'd7;
    localparam logic [4:0] S_A_SP2  = 5'd8;
    localparam logic [4:0] S_A_SP3  = 5'd9;
    localparam logic [4:0] S_A_SP4  = 5'd10;
    localparam logic [4:0] S_F_SZ   = 5'd11;
    localparam logic [4:0] S_F_FT   = 5'd12;
    localparam logic [4:0] S_F_LFRD = 5'd13;
    localparam logic [4:0] S_F_LF   = 5'd14;
    localparam logic [4:0] S_F_LH   = 5'd15;
    localparam logic [4:0] S_F_LFW  = 5'd16;
    localparam logic [4:0] S_F_Q    = 5'd17;
    localparam logic [4:0] S_F_NS   = 5'd18;
    localparam logic [4:0] S_F_NF   = 5'd19;
    localparam logic [4:0] S_F_NH   = 5'd20;
    localparam logic [4:0] S_DONE   = 5'd21;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl.cmd   = btffa_pkg::CMD_NOP;
        unique case (state_reg)
            S_CLR:
            begin
                ctrl.cmd = btffa_pkg::CMD_CLR;
                if (stat.clr_last)
                begin
                    state_next = S_INIT_H;
                end
            end
            S_INIT_H:
            begin
                ctrl.cmd   = btffa_pkg::CMD_INIT_H;
                state_next = S_INIT_F;
            end
            S_INIT_F:
            begin
                ctrl.cmd   = btffa_pkg::CMD_INIT_F;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.cmd   = btffa_pkg::CMD_ACCEPT;
                    state_next = S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                priority if (!stat.is_free && stat.req_big)
                begin
                    ctrl.cmd   = btffa_pkg::CMD_SET_BIG;
                    state_next = S_DONE;
                end
                else if (!stat.is_free)
                begin
                    state_next = S_A_TEST;
                end
                else if (stat.reg_bad)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.cmd   = btffa_pkg::CMD_RD_HS;
                    state_next = S_F_SZ;
                end
            end
            S_A_TEST:
            begin
                if (stat.pos_end)
                begin
                    ctrl.cmd   = btffa_pkg::CMD_SET_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.cmd   = btffa_pkg::CMD_RD_HS;
                    state_next = S_A_HS;
                end
            end
            S_A_HS:
            begin
                if (stat.hs_bad)
                begin
                    ctrl.cmd   = btffa_pkg::CMD_SET_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.cmd   = btffa_pkg::CMD_RD_FT;
                    state_next = S_A_FT;
                end
            end
            S_A_FT:
            begin
                priority if (stat.fit && stat.split)
                begin
                    ctrl.cmd   = btffa_pkg::CMD_SPLIT1;
                    state_next = S_A_SP2;
                end
                else if (stat.fit)
                begin
                    ctrl.cmd   = btffa_pkg::CMD_TAKE;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.cmd   = btffa_pkg::CMD_NEXT;
                    state_next = S_A_TEST;
                end
            end
            S_A_SP2:
            begin
                ctrl.cmd   = btffa_pkg::CMD_SPLIT2;
                state_next = S_A_SP3;
            end
            S_A_SP3:
            begin
                ctrl.cmd   = btffa_pkg::CMD_SPLIT3;
                state_next = S_A_SP4;
            end
            S_A_SP4:
            begin
                ctrl.cmd   = btffa_pkg::CMD_SPLIT4;
                state_next = S_DONE;
            end
            S_F_SZ:
            begin
                if (stat.hs_bad)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.cmd   = btffa_pkg::CMD_RD_FT;
                    state_next = S_F_FT;
                end
            end
            S_F_FT:
            begin
                priority if (!stat.ft_match)
                begin
                    state_next = S_DONE;
                end
                else if (stat.p_zero)
                begin
                    ctrl.cmd   = btffa_pkg::CMD_F_CLR_FT;
                    state_next = S_F_Q;
                end
                else
                begin
                    ctrl.cmd   = btffa_pkg::CMD_F_CLR_FT;
                    state_next = S_F_LFRD;
                end
            end
            S_F_LFRD:
            begin
                ctrl.cmd   = btffa_pkg::CMD_F_RD_LF;
                state_next = S_F_LF;
            end
            S_F_LF:
            begin
                if (stat.lf_ok)
                begin
                    ctrl.cmd   = btffa_pkg::CMD_F_RD_LH;
                    state_next = S_F_LH;
                end
                else
                begin
                    state_next = S_F_Q;
                end
            end
            S_F_LH:
            begin
                ctrl.cmd   = btffa_pkg::CMD_F_WR_LH;
                state_next = S_F_LFW;
            end
            S_F_LFW:
            begin
                ctrl.cmd   = btffa_pkg::CMD_F_WR_LF;
                state_next = S_F_Q;
            end
            S_F_Q:
            begin
                if (stat.q_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.cmd   = btffa_pkg::CMD_F_RD_NS;
                    state_next = S_F_NS;
                end
            end
            S_F_NS:
            begin
                if (stat.ns_bad)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.cmd   = btffa_pkg::CMD_F_RD_NF;
                    state_next = S_F_NF;
                end
            end
            S_F_NF:
            begin
                if (stat.nf_even)
                begin
                    ctrl.cmd   = btffa_pkg::CMD_F_WR_NF;
                    state_next = S_F_NH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_F_NH:
            begin
                ctrl.cmd   = btffa_pkg::CMD_F_WR_NH;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.cmd   = btffa_pkg::CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/btffa_dp.sv
module btffa_dp #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  btffa_pkg::ctrl_t  ctrl,
    output btffa_pkg::stat_t  stat,
    input  logic              in_op,
    input  logic [15:0]       in_req,
    input  logic [15:0]       in_region,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       out_offset,
    output logic [1:0]        out_status
);

    localparam int DEPTH = HEAP_BYTES / 2;
    localparam int IW    = $clog2(DEPTH);
    localparam logic [16:0] CHUNK_LIMIT = 17'(HEAP_BYTES - 2);
    localparam logic [16:0] MAX_REQUEST = 17'(HEAP_BYTES - 8);

    logic [IW-1:0] clr_cnt_reg;
    logic          op_reg;
    logic [15:0]   req_reg;
    logic [15:0]   region_reg;
    logic [16:0]   need_reg;
    logic [16:0]   pos_reg;
    logic [15:0]   hs_reg;
    logic [15:0]   ft_reg;
    logic [15:0]   start_reg;
    logic [15:0]   csz_reg;
    logic [16:0]   q_reg;
    logic [15:0]   ns_reg;
    logic [15:0]   res_off_reg;
    logic [1:0]    res_st_reg;
    logic          out_valid_reg;
    logic [15:0]   out_offset_reg;
    logic [1:0]    out_status_reg;

    logic [16:0]   need_next;
    logic [16:0]   addr;
    logic [15:0]   wdata;
    logic          we;
    logic [15:0]   rdata;
    logic [16:0]   pos_rd;
    logic [16:0]   q_rd;
    logic [16:0]   q_calc;
    logic [16:0]   rd17;
    logic [15:0]   lh_sum;

    assign rd17   = {1'b0, rdata};
    assign pos_rd = pos_reg + rd17;
    assign q_rd   = q_reg + rd17;
    assign q_calc = {1'b0, start_reg} + {1'b0, csz_reg};
    assign lh_sum = rdata + hs_reg;

    // round up to whole words, then room for both tags
    assign need_next = (({1'b0, in_req} + 17'd3) & ~17'd3) + 17'd8;

    btffa_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_tags (
        .clk   (clk),
        .we    (we),
        .addr  (addr[IW:1]),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_comb
    begin
        addr  = pos_reg;
        wdata = 16'd0;
        we    = 1'b0;
        unique case (ctrl.cmd)
            btffa_pkg::CMD_CLR:
            begin
                addr = 17'({clr_cnt_reg, 1'b0});
                we   = 1'b1;
            end
            btffa_pkg::CMD_INIT_H:
            begin
                addr  = 17'd0;
                wdata = CHUNK_LIMIT[15:0];
                we    = 1'b1;
            end
            btffa_pkg::CMD_INIT_F:
            begin
                addr  = CHUNK_LIMIT - 17'd4;
                wdata = CHUNK_LIMIT[15:0];
                we    = 1'b1;
            end
            btffa_pkg::CMD_RD_HS:
            begin
                addr = pos_reg;
            end
            btffa_pkg::CMD_RD_FT:
            begin
                addr = pos_rd - 17'd4;
            end
            btffa_pkg::CMD_TAKE:
            begin
                addr  = pos_reg + {1'b0, hs_reg} - 17'd4;
                wdata = hs_reg + 16'd1;
                we    = 1'b1;
            end
            btffa_pkg::CMD_SPLIT1:
            begin
                addr  = pos_reg + need_reg;
                wdata = hs_reg - need_reg[15:0];
                we    = 1'b1;
            end
            btffa_pkg::CMD_SPLIT2:
            begin
                addr  = pos_reg + {1'b0, hs_reg} - 17'd4;
                wdata = ft_reg - need_reg[15:0];
                we    = 1'b1;
            end
            btffa_pkg::CMD_SPLIT3:
            begin
                addr  = pos_reg;
                wdata = need_reg[15:0];
                we    = 1'b1;
            end
            btffa_pkg::CMD_SPLIT4:
            begin
                addr  = pos_reg + need_reg - 17'd4;
                wdata = need_reg[15:0] + 16'd1;
                we    = 1'b1;
            end
            btffa_pkg::CMD_F_CLR_FT:
            begin
                addr  = pos_reg + {1'b0, hs_reg} - 17'd4;
                wdata = hs_reg;
                we    = 1'b1;
            end
            btffa_pkg::CMD_F_RD_LF:
            begin
                addr = pos_reg - 17'd4;
            end
            btffa_pkg::CMD_F_RD_LH:
            begin
                addr = pos_reg - rd17;
            end
            btffa_pkg::CMD_F_WR_LH:
            begin
                addr  = pos_reg - {1'b0, ft_reg};
                wdata = lh_sum;
                we    = 1'b1;
            end
            btffa_pkg::CMD_F_WR_LF:
            begin
                addr  = pos_reg + {1'b0, hs_reg} - 17'd4;
                wdata = hs_reg + ft_reg;
                we    = 1'b1;
            end
            btffa_pkg::CMD_F_RD_NS:
            begin
                addr = q_calc;
            end
            btffa_pkg::CMD_F_RD_NF:
            begin
                addr = q_rd - 17'd4;
            end
            btffa_pkg::CMD_F_WR_NF:
            begin
                addr  = q_reg + {1'b0, ns_reg} - 17'd4;
                wdata = rdata + csz_reg;
                we    = 1'b1;
            end
            btffa_pkg::CMD_F_WR_NH:
            begin
                addr  = {1'b0, start_reg};
                wdata = csz_reg + ns_reg;
                we    = 1'b1;
            end
            default:
            begin
                addr = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.cmd == btffa_pkg::CMD_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ctrl.cmd == btffa_pkg::CMD_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.cmd)
            btffa_pkg::CMD_ACCEPT:
            begin
                op_reg      <= in_op;
                req_reg     <= in_req;
                region_reg  <= in_region;
                need_reg    <= need_next;
                pos_reg     <= in_op ? {1'b0, in_region - 16'd4} : 17'd0;
                res_off_reg <= 16'd0;
                res_st_reg  <= btffa_pkg::ST_DONE;
            end
            btffa_pkg::CMD_RD_FT:
            begin
                hs_reg <= rdata;
            end
            btffa_pkg::CMD_NEXT:
            begin
                pos_reg <= pos_reg + {1'b0, hs_reg};
            end
            btffa_pkg::CMD_TAKE,
            btffa_pkg::CMD_SPLIT4:
            begin
                res_off_reg <= 16'(pos_reg + 17'd4);
            end
            btffa_pkg::CMD_SPLIT1:
            begin
                ft_reg <= rdata;
            end
            btffa_pkg::CMD_SET_BIG:
            begin
                res_st_reg <= btffa_pkg::ST_BIG;
            end
            btffa_pkg::CMD_SET_NOFIT:
            begin
                res_st_reg <= btffa_pkg::ST_NOFIT;
            end
            btffa_pkg::CMD_F_CLR_FT:
            begin
                start_reg <= pos_reg[15:0];
                csz_reg   <= hs_reg;
            end
            btffa_pkg::CMD_F_RD_LH:
            begin
                ft_reg <= rdata;
            end
            btffa_pkg::CMD_F_WR_LH:
            begin
                // merged size as the header now holds it
                csz_reg   <= lh_sum;
                start_reg <= 16'(pos_reg - {1'b0, ft_reg});
            end
            btffa_pkg::CMD_F_RD_NS:
            begin
                q_reg <= q_calc;
            end
            btffa_pkg::CMD_F_RD_NF:
            begin
                ns_reg <= rdata;
            end
            btffa_pkg::CMD_OUT:
            begin
                out_offset_reg <= res_off_reg;
                out_status_reg <= res_st_reg;
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    always_comb
    begin
        stat.clr_last = (clr_cnt_reg == IW'(DEPTH - 1));
        stat.is_free  = op_reg;
        stat.req_big  = ({1'b0, req_reg} > MAX_REQUEST);
        stat.reg_bad  = (region_reg < 16'd4) || (region_reg[1:0] != 2'b00);
        stat.pos_end  = (pos_reg >= CHUNK_LIMIT);
        stat.hs_bad   = (rdata < 16'd8) || (pos_rd > CHUNK_LIMIT);
        stat.fit      = !rdata[0] && ({1'b0, hs_reg} >= need_reg);
        stat.split    = ({1'b0, hs_reg} >= need_reg + 17'd8);
        stat.ft_match = (rd17 == {1'b0, hs_reg} + 17'd1);
        stat.p_zero   = (pos_reg == 17'd0);
        stat.lf_ok    = !rdata[0] && (rdata >= 16'd8) && (rd17 <= pos_reg);
        stat.q_end    = (q_calc >= CHUNK_LIMIT);
        stat.ns_bad   = (rdata < 16'd8) || (q_rd > CHUNK_LIMIT);
        stat.nf_even  = !rdata[0];
        stat.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_offset = out_offset_reg;
    assign out_status = out_status_reg;

endmodule

// File: rtl/boundary_tag_first_fit_allocator.sv
// First-fit heap allocator with boundary tags and coalescing. Tags live in a
// single-port RAM of HEAP_BYTES/2 halfwords. After reset the block clears the
// whole tag RAM, then lays down the initial chunk, and only then raises
// s_axis_tready. An allocate walks the chunks in order from the start of the
// heap and splits the chosen chunk when it is large enough, so its time grows
// with fragmentation; a free merges the chunk with its free neighbours.
// Items are handled one at a time; a finished result sits in an output register
// while the next item is taken.
module boundary_tag_first_fit_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // request_bytes[15:0], region_offset[31:16]
    input  logic [0:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // result_offset[15:0], status[17:16], zero
);

    btffa_pkg::ctrl_t ctrl;
    btffa_pkg::stat_t stat;
    logic [15:0]      res_offset;
    logic [1:0]       res_status;

    btffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    btffa_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .in_op      (s_axis_tuser[0]),
        .in_req     (s_axis_tdata[15:0]),
        .in_region  (s_axis_tdata[31:16]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_offset (res_offset),
        .out_status (res_status)
    );

    assign m_axis_tdata = {6'd0, res_status, res_offset};

endmodule
